// File: sv/dnm_pkg.sv
`default_nettype none

package dnm_pkg;

   // Field widths fixed by the interface.
   localparam int DIST_W  = 40;
   localparam int INDEX_W = 6;
   localparam int ELEM_W  = 16;

   // Squared distance limit after reset: 0.36 in Q16.24.
   localparam logic [DIST_W-1:0] LIMIT_RESET = 40'd6039798;

   // Command codes of an input transfer.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ENROLL = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Result kinds of an output transfer.
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_ENROLL = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [ELEM_W-1:0] element_value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic               table_full;
      logic               matched;
      logic [INDEX_W-1:0] match_index;
      logic [DIST_W-1:0]  best_distance_squared;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_DRAIN,
      ST_ANSWER
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic fill_step;
      logic scan_step;
      logic answer;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic imm_result;
      logic elem_done;
      logic need_fill;
      logic is_query;
      logic fill_last;
      logic fill_query;
      logic count_zero;
      logic scan_last;
      logic pipe_busy;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

// File: sv/dnm_ram.sv
`default_nettype none

module dnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: sv/dnm_ctrl.sv
`default_nettype none

module dnm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dnm_pkg::sts_type sts,
   output dnm_pkg::ctl_type      ctl
);

   dnm_pkg::state_type state_ff;
   dnm_pkg::state_type state_in;

   // A result produced at once needs a free output register.
   assign req_stall = (state_ff != dnm_pkg::ST_IDLE) || (sts.imm_result && sts.rsp_busy);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dnm_pkg::ST_IDLE: begin
            if (req_valid && !req_stall && sts.elem_done) begin
               if (sts.need_fill) begin
                  state_in = dnm_pkg::ST_FILL;
               end else if (sts.is_query) begin
                  state_in = sts.count_zero ? dnm_pkg::ST_ANSWER : dnm_pkg::ST_SCAN;
               end
            end
         end
         dnm_pkg::ST_FILL: begin
            if (sts.fill_last) begin
               if (sts.fill_query) begin
                  state_in = sts.count_zero ? dnm_pkg::ST_ANSWER : dnm_pkg::ST_SCAN;
               end else begin
                  state_in = dnm_pkg::ST_IDLE;
               end
            end
         end
         dnm_pkg::ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = dnm_pkg::ST_DRAIN;
            end
         end
         dnm_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = dnm_pkg::ST_ANSWER;
            end
         end
         dnm_pkg::ST_ANSWER: begin
            if (!sts.rsp_busy) begin
               state_in = dnm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dnm_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         dnm_pkg::ST_IDLE:   ctl.take      = req_valid && !req_stall;
         dnm_pkg::ST_FILL:   ctl.fill_step = 1'b1;
         dnm_pkg::ST_SCAN:   ctl.scan_step = 1'b1;
         dnm_pkg::ST_DRAIN:  ctl = '0;
         dnm_pkg::ST_ANSWER: ctl.answer    = !sts.rsp_busy;
         default:            ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dnm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The answer is taken only once every distance has been compared.
   a_answer_after_drain: assert property (@(posedge clock) disable iff (reset)
      ctl.answer |-> !sts.pipe_busy)
      else $error("answer loaded while the distance pipeline still works");

endmodule

`default_nettype wire

// File: sv/dnm_datapath.sv
`default_nettype none

module dnm_datapath #(
   parameter int MAX_ENTRIES       = 64,
   parameter int DESCRIPTOR_LENGTH = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dnm_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output dnm_pkg::rsp_type                     rsp_data,
   input  wire logic [dnm_pkg::DIST_W-1:0]      match_limit,
   input  wire dnm_pkg::ctl_type                ctl,
   output dnm_pkg::sts_type                     sts
);

   localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int KW    = (DESCRIPTOR_LENGTH > 1) ? $clog2(DESCRIPTOR_LENGTH) : 1;
   localparam int PW    = $clog2(DESCRIPTOR_LENGTH + 1);
   localparam int TOTAL = MAX_ENTRIES * DESCRIPTOR_LENGTH;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int DW    = dnm_pkg::DIST_W;
   localparam int EL    = dnm_pkg::ELEM_W;

   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);
   localparam logic [PW-1:0] LEN       = PW'(DESCRIPTOR_LENGTH);
   localparam logic [KW-1:0] K_LAST    = KW'(DESCRIPTOR_LENGTH - 1);
   localparam logic [AW-1:0] STRIDE    = AW'(DESCRIPTOR_LENGTH);

   // Load state.
   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] ptr_ff, ptr_in;
   logic          loading_query_ff, loading_query_in;
   logic [AW-1:0] wr_base_ff, wr_base_in;
   logic [KW-1:0] fill_k_ff, fill_k_in;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;

   // Scan counters.
   logic [KW-1:0] scan_k_ff, scan_k_in;
   logic [EW-1:0] scan_e_ff, scan_e_in;
   logic [AW-1:0] scan_base_ff, scan_base_in;

   // Distance pipeline.
   logic          s1_v_ff, s1_first_ff, s1_last_ff;
   logic [EW-1:0] s1_e_ff;
   logic          s2_v_ff, s2_first_ff, s2_last_ff;
   logic [EW-1:0] s2_e_ff;
   logic [31:0]   sq_ff;
   logic [DW-1:0] acc_ff, acc_in;
   logic          s3_v_ff;
   logic [EW-1:0] s3_e_ff;
   logic [DW-1:0] best_ff, best_in;
   logic [EW-1:0] best_e_ff, best_e_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   dnm_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_load;

   // Decode of the offered item.
   logic          is_enroll, is_query, is_elem, full, elem_done;
   logic [KW-1:0] eff_ptr;
   logic [PW-1:0] ptr_next;

   // Memory ports.
   logic          q_we, t_we;
   logic [KW-1:0] q_waddr, q_raddr;
   logic [AW-1:0] t_waddr, t_raddr;
   logic [EL-1:0] q_wdata, t_wdata, q_rdata, t_rdata;

   // Arithmetic.
   logic signed [EL:0]     diff;
   logic signed [2*EL+1:0] sq_full;
   logic [DW:0]            acc_sum;
   logic                   matched;

   always_comb begin
      is_enroll = req_data.cmd == dnm_pkg::CMD_ENROLL;
      is_query  = req_data.cmd == dnm_pkg::CMD_QUERY;
      is_elem   = is_enroll || is_query;
      full      = count_ff == COUNT_MAX;
      // A switch of descriptor kind drops the partial descriptor.
      eff_ptr   = (is_query != loading_query_ff) ? '0 : ptr_ff;
      ptr_next  = PW'(eff_ptr) + PW'(1);
      elem_done = req_data.last_element || (ptr_next == LEN);
   end

   // Status to the controller.
   always_comb begin
      sts.imm_result = (req_data.cmd == dnm_pkg::CMD_CLEAR) || (is_enroll && elem_done);
      sts.elem_done  = is_elem && elem_done;
      sts.need_fill  = is_elem && elem_done && (ptr_next != LEN) && (is_query || !full);
      sts.is_query   = is_query;
      sts.fill_last  = fill_k_ff == K_LAST;
      sts.fill_query = loading_query_ff;
      sts.count_zero = count_ff == '0;
      sts.scan_last  = (scan_k_ff == K_LAST) && ((CW'(scan_e_ff) + CW'(1)) == count_ff);
      sts.pipe_busy  = s1_v_ff || s2_v_ff || s3_v_ff;
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   // Memory write and read ports; the tail of a short descriptor is written with zeros.
   always_comb begin
      q_we    = (ctl.take && is_query) || (ctl.fill_step && loading_query_ff);
      q_waddr = ctl.fill_step ? fill_k_ff : eff_ptr;
      q_wdata = ctl.fill_step ? '0 : req_data.element_value;
      t_we    = (ctl.take && is_enroll && !full) || (ctl.fill_step && !loading_query_ff);
      t_waddr = ctl.fill_step ? fill_addr_ff : (wr_base_ff + AW'(eff_ptr));
      t_wdata = ctl.fill_step ? '0 : req_data.element_value;
      q_raddr = scan_k_ff;
      t_raddr = scan_base_ff + AW'(scan_k_ff);
   end

   dnm_ram #(.WIDTH(EL), .DEPTH(DESCRIPTOR_LENGTH)) u_query_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   dnm_ram #(.WIDTH(EL), .DEPTH(TOTAL)) u_desc_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   // Load bookkeeping and scan counters.
   always_comb begin
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      loading_query_in = loading_query_ff;
      wr_base_in       = wr_base_ff;
      fill_k_in        = fill_k_ff;
      fill_addr_in     = fill_addr_ff;
      scan_k_in        = scan_k_ff;
      scan_e_in        = scan_e_ff;
      scan_base_in     = scan_base_ff;
      if (ctl.take) begin
         scan_k_in    = '0;
         scan_e_in    = '0;
         scan_base_in = '0;
         unique case (req_data.cmd)
            dnm_pkg::CMD_CLEAR: begin
               count_in         = '0;
               ptr_in           = '0;
               loading_query_in = 1'b0;
               wr_base_in       = '0;
            end
            dnm_pkg::CMD_ENROLL, dnm_pkg::CMD_QUERY: begin
               loading_query_in = is_query;
               ptr_in           = elem_done ? '0 : ptr_next[KW-1:0];
               fill_k_in        = ptr_next[KW-1:0];
               fill_addr_in     = wr_base_ff + AW'(ptr_next);
               if (is_enroll && elem_done && !full) begin
                  count_in   = count_ff + CW'(1);
                  wr_base_in = wr_base_ff + STRIDE;
               end
            end
            dnm_pkg::CMD_UNUSED: begin
               count_in = count_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      if (ctl.fill_step) begin
         fill_k_in    = fill_k_ff + KW'(1);
         fill_addr_in = fill_addr_ff + AW'(1);
      end
      if (ctl.scan_step) begin
         if (scan_k_ff == K_LAST) begin
            scan_k_in    = '0;
            scan_e_in    = scan_e_ff + EW'(1);
            scan_base_in = scan_base_ff + STRIDE;
         end else begin
            scan_k_in = scan_k_ff + KW'(1);
         end
      end
   end

   // Squared difference of the element pair read last cycle.
   always_comb begin
      diff    = $signed({q_rdata[EL-1], q_rdata}) - $signed({t_rdata[EL-1], t_rdata});
      sq_full = diff * diff;
   end

   // Saturating sum per entry, then the running minimum with the lowest index kept on a tie.
   always_comb begin
      acc_sum = {1'b0, acc_ff} + (DW + 1)'(sq_ff);
      acc_in  = acc_ff;
      if (s2_v_ff) begin
         if (s2_first_ff) begin
            acc_in = DW'(sq_ff);
         end else begin
            acc_in = acc_sum[DW] ? {DW{1'b1}} : acc_sum[DW-1:0];
         end
      end
      best_in   = best_ff;
      best_e_in = best_e_ff;
      if (ctl.take) begin
         best_in   = {DW{1'b1}};
         best_e_in = '0;
      end else if (s3_v_ff && ((s3_e_ff == '0) || (acc_ff < best_ff))) begin
         best_in   = acc_ff;
         best_e_in = s3_e_ff;
      end
   end

   // Result register contents.
   always_comb begin
      matched      = (count_ff != '0) && (best_ff <= match_limit);
      rsp_load     = (ctl.take && sts.imm_result) || ctl.answer;
      rsp_in       = rsp_ff;
      if (ctl.answer) begin
         rsp_in.result_kind           = dnm_pkg::KIND_QUERY;
         rsp_in.table_full            = 1'b0;
         rsp_in.matched               = matched;
         rsp_in.match_index           = matched ? dnm_pkg::INDEX_W'(best_e_ff) : '0;
         rsp_in.best_distance_squared = best_ff;
      end else if (ctl.take) begin
         rsp_in             = '0;
         rsp_in.result_kind = is_enroll ? dnm_pkg::KIND_ENROLL : dnm_pkg::KIND_CLEAR;
         rsp_in.table_full  = is_enroll && full;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         ptr_ff           <= '0;
         loading_query_ff <= 1'b0;
         wr_base_ff       <= '0;
         fill_k_ff        <= '0;
         fill_addr_ff     <= '0;
         scan_k_ff        <= '0;
         scan_e_ff        <= '0;
         scan_base_ff     <= '0;
         s1_v_ff          <= 1'b0;
         s2_v_ff          <= 1'b0;
         s3_v_ff          <= 1'b0;
         best_ff          <= {DW{1'b1}};
         best_e_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         ptr_ff           <= ptr_in;
         loading_query_ff <= loading_query_in;
         wr_base_ff       <= wr_base_in;
         fill_k_ff        <= fill_k_in;
         fill_addr_ff     <= fill_addr_in;
         scan_k_ff        <= scan_k_in;
         scan_e_ff        <= scan_e_in;
         scan_base_ff     <= scan_base_in;
         s1_v_ff          <= ctl.scan_step;
         s2_v_ff          <= s1_v_ff;
         s3_v_ff          <= s2_v_ff && s2_last_ff;
         best_ff          <= best_in;
         best_e_ff        <= best_e_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_first_ff <= scan_k_ff == '0;
      s1_last_ff  <= scan_k_ff == K_LAST;
      s1_e_ff     <= scan_e_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_e_ff     <= s1_e_ff;
      sq_ff       <= sq_full[31:0];
      acc_ff      <= acc_in;
      s3_e_ff     <= s2_e_ff;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // A new result never overwrites one that still waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a result is pending");

   // The table never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond table size");

   // A compare follows only the final element of an entry.
   a_compare_on_last: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> $past(s2_v_ff && s2_last_ff))
      else $error("distance compared before the entry sum was complete");

   // A query answer never reports a full table.
   a_query_not_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_kind == dnm_pkg::KIND_QUERY) |-> !rsp_ff.table_full)
      else $error("query answer flags a full table");

endmodule

`default_nettype wire

// File: sv/descriptor_nearest_match_core.sv
`default_nettype none

// Channel   Direction  Handshake             Transfer contents
// req_      in         req_valid/req_stall   dnm_pkg::req_type: cmd, element, last flag
// rsp_      out        rsp_valid/rsp_stall   dnm_pkg::rsp_type: kind, full, match, index, dist
// csr_      in/out     APB, pready tied high match limit, byte address 0, 40 of 64 bits
//
// A clear or a descriptor element is taken while the controller is idle and, if it
// yields a result at once, while the output register is free. A descriptor that ends
// short has the elements not given written with zeros. A query's final element then
// starts a walk of every stored element through the descriptor memory read port,
// after which the distance pipeline drains and the answer is loaded.
// Synchronous reset empties the table; no memory is cleared.
// A stalled result does not block element transfers that produce no result.

module descriptor_nearest_match_core #(
   parameter int MAX_ENTRIES       = 64,
   parameter int DESCRIPTOR_LENGTH = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dnm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dnm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [63:0]      csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   // Register index taken from the byte address.
   localparam logic REG_MATCH_LIMIT = 1'b0;

   logic [dnm_pkg::DIST_W-1:0] limit_ff, limit_in;
   logic                       csr_write;
   dnm_pkg::ctl_type           ctl;
   dnm_pkg::sts_type           sts;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (csr_paddr[3] == REG_MATCH_LIMIT)) begin
         limit_in = csr_pwdata[dnm_pkg::DIST_W-1:0];
      end
      csr_prdata = (csr_paddr[3] == REG_MATCH_LIMIT) ? 64'(limit_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dnm_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   dnm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   dnm_datapath #(
      .MAX_ENTRIES       (MAX_ENTRIES),
      .DESCRIPTOR_LENGTH (DESCRIPTOR_LENGTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .match_limit (limit_ff),
      .ctl         (ctl),
      .sts         (sts)
   );

endmodule

`default_nettype wire
